[rtl/modular_exponentiation_core_macros.svh]
// Assertion macros for the modular exponentiation core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define MEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define MEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define MEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/mexp_pkg.sv]
// Package for the modular exponentiation core: item structs and defaults.
// No dependencies.
`default_nettype none

package mexp_pkg;

  // Default operand width
  localparam int MEXP_WIDTH = 32;

  // Input item
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] exponent;
    logic [31:0] modulus;
  } mexp_in_t;

  // Result item
  typedef struct packed {
    logic [31:0] power_result;
    logic        modulus_zero_error;
  } mexp_out_t;

endpackage

`default_nettype wire

[rtl/modular_exponentiation_core.sv]
// Modular exponentiation core: right-to-left square-and-multiply on one modular adder.
// Depends on mexp_pkg and modular_exponentiation_core_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall | mexp_in_t  (base, exponent, modulus)
//   out     | output    | out_valid/out_stall | mexp_out_t (power_result, modulus_zero_error)
//
// Every modular product runs as WIDTH doubling steps plus one add step per set multiplier
// bit, all on a single (x + y) mod m adder.
// One item costs a base reduction plus, per exponent bit up to the top set bit, a multiply
// for set bits and a square below the top bit.
// A zero modulus goes straight to the done state with a zero result and modulus_zero_error
// set; a zero exponent still runs the base reduction first.
// in_stall is high from acceptance until the result moves into the output register; the
// output register holds while out_stall is high. Only state and out_valid are reset.
`default_nettype none

`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire mexp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output mexp_out_t      out_data
);

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DBL  = 5'b00010,
    S_ADD  = 5'b00100,
    S_NEXT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULT,
    OP_SQUARE
  } op_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [WIDTH-1:0]   base_r, base_nxt;
  logic [WIDTH-1:0]   exp_r, exp_nxt;
  logic [WIDTH-1:0]   mod_r, mod_nxt;
  logic [WIDTH-1:0]   acc_r, acc_nxt;
  logic [WIDTH-1:0]   prod_r, prod_nxt;
  logic [WIDTH-1:0]   opa_r, opa_nxt;
  logic [WIDTH-1:0]   opb_r, opb_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  mexp_out_t          out_data_r, out_data_nxt;

  // Shared modular adder
  logic [WIDTH-1:0]   unit_y;
  logic [WIDTH:0]     unit_sum;
  logic [WIDTH:0]     unit_diff;
  logic [WIDTH-1:0]   unit_res;

  // Sequencer control
  logic               bit_end;
  logic               start_op;
  op_t                start_kind;
  logic [WIDTH-1:0]   start_a;
  logic [WIDTH-1:0]   start_b;
  logic [WIDTH-1:0]   in_base_w;
  logic [WIDTH-1:0]   in_exp_w;
  logic [WIDTH-1:0]   in_mod_w;

  // Take the low WIDTH bits of each input field
  assign in_base_w = WIDTH'({{WIDTH{1'b0}}, in_data.base});
  assign in_exp_w  = WIDTH'({{WIDTH{1'b0}}, in_data.exponent});
  assign in_mod_w  = WIDTH'({{WIDTH{1'b0}}, in_data.modulus});

  // Form (prod + y) mod m; both operands stay below m
  assign unit_sum  = {1'b0, prod_r} + {1'b0, unit_y};
  assign unit_diff = unit_sum - {1'b0, mod_r};
  assign unit_res  = (unit_sum >= {1'b0, mod_r}) ? unit_diff[WIDTH-1:0]
                                                 : unit_sum[WIDTH-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Step the sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    unit_y        = prod_r;
    bit_end       = 1'b0;
    start_op      = 1'b0;
    start_kind    = OP_REDUCE;
    start_a       = opa_r;
    start_b       = opb_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          base_nxt = in_base_w;
          exp_nxt  = in_exp_w;
          mod_nxt  = in_mod_w;
          if (in_mod_w == '0) begin
            err_nxt   = 1'b1;
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // Reduce the base as the product 1 * base mod m
            err_nxt    = 1'b0;
            acc_nxt    = WIDTH'(1);
            start_op   = 1'b1;
            start_kind = OP_REDUCE;
            start_a    = WIDTH'(1);
            start_b    = in_base_w;
          end
        end
      end
      S_DBL: begin
        unit_y   = prod_r;
        prod_nxt = unit_res;
        if (opb_r[WIDTH-1]) begin
          state_nxt = S_ADD;
        end else begin
          bit_end = 1'b1;
        end
      end
      S_ADD: begin
        unit_y   = opa_r;
        prod_nxt = unit_res;
        bit_end  = 1'b1;
      end
      S_NEXT: begin
        if (exp_r == '0) begin
          state_nxt = S_DONE;
        end else if (exp_r[0]) begin
          start_op   = 1'b1;
          start_kind = OP_MULT;
          start_a    = acc_r;
          start_b    = base_r;
        end else begin
          start_op   = 1'b1;
          start_kind = OP_SQUARE;
          start_a    = base_r;
          start_b    = base_r;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.power_result       = 32'({32'b0, acc_r});
          out_data_nxt.modulus_zero_error = err_r;
          state_nxt                       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Advance the multiplier bit; finish the product after the last one
    if (bit_end) begin
      opb_nxt = opb_r << 1;
      if (cnt_r != '0) begin
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_DBL;
      end else begin
        case (op_r)
          OP_REDUCE: begin
            base_nxt  = unit_res;
            state_nxt = S_NEXT;
          end
          OP_MULT: begin
            acc_nxt = unit_res;
            if (exp_r[WIDTH-1:1] == '0) begin
              state_nxt = S_DONE;
            end else begin
              start_op   = 1'b1;
              start_kind = OP_SQUARE;
              start_a    = base_r;
              start_b    = base_r;
            end
          end
          OP_SQUARE: begin
            base_nxt  = unit_res;
            exp_nxt   = exp_r >> 1;
            state_nxt = S_NEXT;
          end
          default: begin
            state_nxt = S_NEXT;
          end
        endcase
      end
    end

    // Load a new product: multiplicand, multiplier, cleared accumulator
    if (start_op) begin
      op_nxt    = start_kind;
      opa_nxt   = start_a;
      opb_nxt   = start_b;
      prod_nxt  = '0;
      cnt_nxt   = CNT_W'(WIDTH - 1);
      state_nxt = S_DBL;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    mod_r      <= mod_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    cnt_r      <= cnt_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `MEC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && out_data_r.modulus_zero_error, out_data_r.power_result == 32'd0, "zero-modulus result is not zero")
  `MEC_ASSERT_IMP(a_prod_below_mod, clk, rst_n, state_r == S_DBL || state_r == S_ADD, prod_r < mod_r, "partial product not reduced")
  `MEC_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE, "accepted item did not start work")
  `MEC_ASSERT_IMP(a_add_after_dbl, clk, rst_n, state_r == S_ADD, $past(state_r) == S_DBL && $past(opb_r[WIDTH-1]), "add step without set multiplier bit")

endmodule

`default_nettype wire
